// ===== rtl/utf8_random_line_rewrapper_macros.svh =====
// Assertion macros shared by the checkers of the UTF-8 line rewrapper.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef UTF8_RANDOM_LINE_REWRAPPER_MACROS_SVH
`define UTF8_RANDOM_LINE_REWRAPPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define U8RW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8rw checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define U8RW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8rw checker: next-cycle property failed");

// The consequent must hold in the cycle after reset is sampled high.
`define U8RW_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("u8rw checker: post-reset property failed");

`endif

// ===== rtl/u8rw_pkg.sv =====
// Shared types and constants of the UTF-8 line rewrapper.
// Used by every module of the block and by its checker; depends on nothing.
`timescale 1ns / 1ps

package u8rw_pkg;

  // Width of the line length counters, unless the top level overrides it.
  localparam int DEFAULT_LENGTH_BITS = 13;

  // Configuration registers.
  localparam int REG_BITS       = 13;
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_LENGTH       = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_LENGTH       = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_CUT_LENGTH = 2'd2;
  localparam logic [REG_BITS-1:0] MIN_LENGTH_RESET = 13'd0;
  localparam logic [REG_BITS-1:0] MAX_LENGTH_RESET = 13'h1fff;
  localparam logic [REG_BITS-1:0] FIRST_CUT_RESET  = 13'd0;

  // Random draw: a 32-bit word scaled by a span of up to 2^REG_BITS.
  localparam int RAND_BITS = 32;
  localparam int SPAN_BITS = REG_BITS + 1;

  // Input item layout.
  localparam int BYTE_BITS       = 8;
  localparam int IN_TDATA_BITS   = BYTE_BITS + RAND_BITS;
  localparam int DATA_BYTE_LSB   = 0;
  localparam int RANDOM_WORD_LSB = BYTE_BITS;
  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  localparam logic [BYTE_BITS-1:0] LF = 8'h0a;

  // A group is at most four bytes; the last one never needs storing.
  localparam int HELD_DEPTH      = 3;
  localparam int HELD_COUNT_BITS = 2;

  // One input item yields at most five result bytes.
  localparam int MAX_RESULTS = 5;
  localparam int COUNT_BITS  = 3;

  // Sequencer state: the value is the length of the group being collected.
  typedef enum logic [2:0] {
    SEQ_IDLE  = 3'd0,
    SEQ_WAIT2 = 3'd2,
    SEQ_WAIT3 = 3'd3,
    SEQ_WAIT4 = 3'd4
  } seq_state_t;

  // All result bytes of one input item, handed from the sequencer to the
  // output stage.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][BYTE_BITS-1:0] bytes;
    logic [MAX_RESULTS-1:0]                used;
    logic [COUNT_BITS-1:0]                 count;
  } burst_t;

endpackage

// ===== rtl/u8rw_draw.sv =====
// Line length registers and the scaled random draw of the next cut length.
// Depends on u8rw_pkg.
`timescale 1ns / 1ps

module u8rw_draw import u8rw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]       cfg_data,
  input  logic [RAND_BITS-1:0]      random_word,
  output logic [REG_BITS-1:0]       draw_value
);

  logic [REG_BITS-1:0]  min_length;
  logic [REG_BITS-1:0]  max_length;
  logic [REG_BITS-1:0]  lo;
  logic [SPAN_BITS-1:0] span;

  logic [REG_BITS-1:0]  new_min;
  logic [REG_BITS-1:0]  new_max;
  logic [REG_BITS-1:0]  lo_next;
  logic [REG_BITS-1:0]  hi_next;
  logic [SPAN_BITS-1:0] span_next;
  logic                 len_we;

  logic [RAND_BITS+SPAN_BITS-1:0] product;
  logic [REG_BITS-1:0]            offset;

  // The ordered pair and its span are settled at write time, so the draw
  // itself is only a multiply and an add.
  always_comb begin
    new_min   = (cfg_index == REG_MIN_LENGTH) ? cfg_data : min_length;
    new_max   = (cfg_index == REG_MAX_LENGTH) ? cfg_data : max_length;
    lo_next   = (new_min <= new_max) ? new_min : new_max;
    hi_next   = (new_min <= new_max) ? new_max : new_min;
    span_next = SPAN_BITS'(hi_next) - SPAN_BITS'(lo_next) + SPAN_BITS'(1);
    len_we    = cfg_we && ((cfg_index == REG_MIN_LENGTH) || (cfg_index == REG_MAX_LENGTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
      max_length <= MAX_LENGTH_RESET;
      lo         <= MIN_LENGTH_RESET;
      span       <= SPAN_BITS'(MAX_LENGTH_RESET) - SPAN_BITS'(MIN_LENGTH_RESET)
                    + SPAN_BITS'(1);
    end else if (len_we) begin
      min_length <= new_min;
      max_length <= new_max;
      lo         <= lo_next;
      span       <= span_next;
    end
  end

  // The scaled offset is always below span, so it fits in REG_BITS.
  always_comb begin
    product    = (RAND_BITS+SPAN_BITS)'(random_word) * (RAND_BITS+SPAN_BITS)'(span);
    offset     = product[RAND_BITS +: REG_BITS];
    draw_value = lo + offset;
  end

endmodule

// ===== rtl/u8rw_seq.sv =====
// UTF-8 group sequencer and line counter: decides the result bytes of one
// item and updates the grouping and line state. Depends on u8rw_pkg.
`timescale 1ns / 1ps

module u8rw_seq import u8rw_pkg::*; #(
  parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic                 func,
  input  logic [BYTE_BITS-1:0] data_byte,
  input  logic                 first_cut_we,
  input  logic [REG_BITS-1:0]  first_cut_value,
  input  logic [REG_BITS-1:0]  draw_value,
  output burst_t               burst
);

  localparam int SUM_BITS = LENGTH_BITS + 1;

  seq_state_t                            seq_state, seq_state_next;
  logic [BYTE_BITS-1:0]                  pending_lead, pending_lead_next;
  logic [HELD_DEPTH-1:0][BYTE_BITS-1:0]  held_bytes, held_bytes_next;
  logic [HELD_COUNT_BITS-1:0]            held_count, held_count_next;
  logic [LENGTH_BITS-1:0]                line_points, line_points_next;
  logic [LENGTH_BITS-1:0]                cut_length;

  logic                                  b_ascii, b_cont, b_lf, b_lead;
  logic                                  pending_valid, is_flush, complete;
  logic [HELD_COUNT_BITS-1:0]            hc_eff;
  logic [HELD_DEPTH-1:0][BYTE_BITS-1:0]  held_eff;
  logic [2:0]                            group_len;
  seq_state_t                            lead_state;

  logic [HELD_COUNT_BITS-1:0]            emit_n;
  logic                                  emit_b, do_grow;
  logic [1:0]                            grow_count;
  logic [SUM_BITS-1:0]                   sum;
  logic                                  cut, close_line;
  logic [LENGTH_BITS-1:0]                line_after;
  logic [COUNT_BITS-1:0]                 n;

  // Byte class and the group as it stands, with a waiting lead byte taken
  // as the first held byte.
  always_comb begin
    b_ascii       = ~data_byte[BYTE_BITS-1];
    b_cont        = (data_byte[BYTE_BITS-1 -: 2] == 2'b10);
    b_lf          = (data_byte == LF);
    b_lead        = !b_ascii && !b_cont;
    is_flush      = (func == FUNC_FLUSH);
    pending_valid = (pending_lead != '0);
    hc_eff        = pending_valid ? HELD_COUNT_BITS'(1) : held_count;
    held_eff      = held_bytes;
    if (pending_valid) begin
      held_eff[0] = pending_lead;
    end
    priority if (data_byte[7:5] == 3'b110) begin
      lead_state = SEQ_WAIT2;
    end else if (data_byte[7:4] == 4'b1110) begin
      lead_state = SEQ_WAIT3;
    end else begin
      lead_state = SEQ_WAIT4;
    end
    unique case (seq_state)
      SEQ_WAIT2: group_len = 3'd2;
      SEQ_WAIT3: group_len = 3'd3;
      SEQ_WAIT4: group_len = 3'd4;
      default:   group_len = 3'd0;
    endcase
    complete = ((3'(hc_eff) + 3'd1) == group_len);
  end

  // What this item emits and how far it advances the line.
  always_comb begin
    emit_n     = '0;
    emit_b     = 1'b0;
    do_grow    = 1'b0;
    grow_count = 2'd0;
    if (is_flush) begin
      emit_n     = hc_eff;
      do_grow    = (hc_eff != '0);
      grow_count = 2'd1;
    end else begin
      unique case (seq_state)
        SEQ_IDLE: begin
          if (!b_lead) begin
            emit_b     = !b_lf;
            do_grow    = 1'b1;
            grow_count = b_lf ? 2'd0 : 2'd1;
          end
        end
        SEQ_WAIT2, SEQ_WAIT3, SEQ_WAIT4: begin
          priority if (b_cont) begin
            if (complete) begin
              emit_n     = hc_eff;
              emit_b     = 1'b1;
              do_grow    = 1'b1;
              grow_count = 2'd1;
            end
          end else if (b_ascii) begin
            // A line feed that closes a broken group is dropped.
            emit_n     = hc_eff;
            emit_b     = !b_lf;
            do_grow    = 1'b1;
            grow_count = b_lf ? 2'd1 : 2'd2;
          end else begin
            emit_n     = hc_eff;
            do_grow    = 1'b1;
            grow_count = 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Line count: a cut inserts a line feed and draws a new length.
  always_comb begin
    sum        = SUM_BITS'(line_points) + SUM_BITS'(grow_count);
    cut        = do_grow && (sum >= SUM_BITS'(cut_length));
    line_after = cut ? '0 : (do_grow ? sum[LENGTH_BITS-1:0] : line_points);
    close_line = is_flush && (line_after != '0);
  end

  // Next sequencer state.
  always_comb begin
    seq_state_next    = seq_state;
    pending_lead_next = pending_lead;
    held_bytes_next   = held_bytes;
    held_count_next   = held_count;
    line_points_next  = is_flush ? '0 : line_after;
    if (is_flush) begin
      seq_state_next    = SEQ_IDLE;
      pending_lead_next = '0;
      held_count_next   = '0;
    end else begin
      pending_lead_next = '0;
      held_count_next   = '0;
      unique case (seq_state)
        SEQ_IDLE: begin
          if (b_lead) begin
            seq_state_next     = lead_state;
            held_bytes_next[0] = data_byte;
            held_count_next    = HELD_COUNT_BITS'(1);
          end
        end
        SEQ_WAIT2, SEQ_WAIT3, SEQ_WAIT4: begin
          priority if (b_cont && !complete) begin
            held_bytes_next[0]      = held_eff[0];
            held_bytes_next[hc_eff] = data_byte;
            held_count_next         = hc_eff + HELD_COUNT_BITS'(1);
          end else if (b_cont || b_ascii) begin
            seq_state_next = SEQ_IDLE;
          end else begin
            // A new lead breaks the group and waits for the next item.
            seq_state_next    = lead_state;
            pending_lead_next = data_byte;
          end
        end
        default: seq_state_next = SEQ_IDLE;
      endcase
    end
  end

  // Result bytes: held bytes, the item byte, the cut line feed, the
  // closing line feed, in that order.
  always_comb begin
    burst = '0;
    for (int i = 0; i < HELD_DEPTH; i++) begin
      if (HELD_COUNT_BITS'(i) < emit_n) begin
        burst.bytes[i] = held_eff[i];
      end
    end
    n = COUNT_BITS'(emit_n);
    if (emit_b) begin
      burst.bytes[n] = data_byte;
      n = n + COUNT_BITS'(1);
    end
    if (cut) begin
      burst.bytes[n] = LF;
      burst.used[n]  = 1'b1;
      n = n + COUNT_BITS'(1);
    end
    if (close_line) begin
      burst.bytes[n] = LF;
      n = n + COUNT_BITS'(1);
    end
    burst.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state    <= SEQ_IDLE;
      pending_lead <= '0;
      held_count   <= '0;
      line_points  <= '0;
      cut_length   <= LENGTH_BITS'(FIRST_CUT_RESET);
    end else begin
      if (fire) begin
        seq_state    <= seq_state_next;
        pending_lead <= pending_lead_next;
        held_count   <= held_count_next;
        line_points  <= line_points_next;
      end
      if (first_cut_we) begin
        cut_length <= LENGTH_BITS'(first_cut_value);
      end else if (fire && cut) begin
        cut_length <= LENGTH_BITS'(draw_value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_bytes <= held_bytes_next;
    end
  end

endmodule

// ===== rtl/u8rw_burst.sv =====
// Output register that holds the result bytes of one item and sends them
// one per cycle while m_tready is high. Depends on u8rw_pkg.
`timescale 1ns / 1ps

module u8rw_burst import u8rw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  burst_t               burst_in,
  output logic                 can_load,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [BYTE_BITS-1:0] m_tdata,
  output logic                 m_tlast,
  output logic                 m_tuser
);

  logic                  busy;
  logic [COUNT_BITS-1:0] idx;
  burst_t                burst_q;
  logic                  at_last;

  always_comb begin
    at_last  = (idx == (burst_q.count - COUNT_BITS'(1)));
    can_load = !busy || (m_tready && at_last);
    m_tvalid = busy;
    m_tdata  = burst_q.bytes[idx];
    m_tuser  = burst_q.used[idx];
    m_tlast  = at_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load && (burst_in.count != '0)) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && m_tready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst_q <= burst_in;
    end
  end

endmodule

// ===== rtl/utf8_random_line_rewrapper.sv =====
// Top level of the UTF-8 line rewrapper with random cut lengths.
// Depends on u8rw_pkg, u8rw_draw, u8rw_seq and u8rw_burst.
`timescale 1ns / 1ps

// The block takes one byte per item and passes UTF-8 text through, breaking
// it into lines whose length in code points is drawn at random between the
// min_length and max_length registers (the smaller of the two is the lower
// bound). Original line feeds in the text are all dropped; a line feed is
// inserted whenever the line count reaches the current cut length, and that
// line feed carries tuser high because it consumed the item's random word.
// first_cut_length sets the length of the first line and reloads the
// current cut length when written. A flush item (s_tuser high) drains an
// unfinished group and a waiting lead byte and closes an open line with a
// final line feed. An accepted item waits in an input register, where the
// sequencer works out all of its result bytes; they are loaded into the
// output register once it is free or handing over its final result, and
// the first result is presented from there. The output register sends one
// result per cycle while m_tready is high, so items that give one result or
// none stream at one item per cycle when the output does not stall, and an
// item is taken in the same cycle as the last result of the previous one
// leaves. The output drain of up to five bytes per item is what sets the
// rate. tlast marks the final result of each item.

module utf8_random_line_rewrapper import u8rw_pkg::*; #(
  parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  // Input items.
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // [7:0] data_byte, [39:8] random_word
  input  logic                      s_tuser,   // [0] func: 0 data byte, 1 flush
  // Result items.
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [BYTE_BITS-1:0]      m_tdata,   // [7:0] out_byte
  output logic                      m_tlast,   // last result of the item
  output logic                      m_tuser,   // [0] random_used
  // Configuration writes.
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]       cfg_data
);

  // Input register.
  logic                 in_valid;
  logic                 in_func;
  logic [BYTE_BITS-1:0] in_byte;
  logic [RAND_BITS-1:0] in_rnd;

  logic                 fire;
  logic                 can_load;
  logic                 first_cut_we;
  logic [REG_BITS-1:0]  draw_value;
  burst_t               burst;

  // An item leaves the input register when the output register is free or
  // is handing over its final byte in this cycle.
  assign fire         = in_valid && can_load;
  assign s_tready     = !in_valid || fire;
  assign first_cut_we = cfg_we && (cfg_index == REG_FIRST_CUT_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= s_tuser;
      in_byte <= s_tdata[DATA_BYTE_LSB +: BYTE_BITS];
      in_rnd  <= s_tdata[RANDOM_WORD_LSB +: RAND_BITS];
    end
  end

  u8rw_draw u_draw (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .random_word (in_rnd),
    .draw_value  (draw_value)
  );

  u8rw_seq #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .func            (in_func),
    .data_byte       (in_byte),
    .first_cut_we    (first_cut_we),
    .first_cut_value (cfg_data),
    .draw_value      (draw_value),
    .burst           (burst)
  );

  u8rw_burst u_burst (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .burst_in (burst),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== rtl/u8rw_checker.sv =====
// Port-level checker of the UTF-8 line rewrapper and its bind statement.
// Depends on u8rw_pkg and utf8_random_line_rewrapper_macros.svh.
`timescale 1ns / 1ps
`include "utf8_random_line_rewrapper_macros.svh"

module u8rw_checker import u8rw_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [BYTE_BITS-1:0] m_tdata,
  input logic                 m_tlast,
  input logic                 m_tuser
);

  // A stalled result keeps its payload.
  `U8RW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

  // A line feed that drew a new length always closes the item's results.
  `U8RW_ASSERT_SAME(a_used_is_last_lf, m_tvalid && m_tuser, (m_tdata == LF) && m_tlast)

  // Input is held back only while results are still waiting.
  `U8RW_ASSERT_SAME(a_stall_needs_output, !s_tready, m_tvalid)

  // Reset leaves nothing to send and the input open.
  `U8RW_ASSERT_AFTER_RESET(a_reset_empty, !m_tvalid && s_tready)

endmodule

bind utf8_random_line_rewrapper u8rw_checker u_checker (.*);
